// File: design/sfd_pkg.sv
// Package for the stereo feedback delay: fixed-point constants, register map
// and default parameter values. No dependencies.

package sfd_pkg;

  // Default sizing of the delay lines and samples
  localparam int DEF_LINE_DEPTH  = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed-point formats of the gains
  localparam int FRAC_BITS = 15;
  localparam int DELAY_W   = 16;
  localparam int GAIN_W    = 15;
  localparam int MIX_W     = 16;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'd31130;
  localparam logic [MIX_W-1:0]  MIX_ONE  = 16'd32768;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH  = 4'd0,
    CFG_FEEDBACK_GAIN = 4'd1,
    CFG_WET_MIX       = 4'd2,
    CFG_PING_PONG     = 4'd3
  } cfg_reg_e;

endpackage

// File: design/stereo_feedback_delay_unit.sv
// Stereo feedback delay with ping-pong cross-feed, top level.
// Depends on sfd_pkg.
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+--------------------------------
//   input     | in        | in_valid_i / in_stall_o | left_in_i, right_in_i
//   output    | out       | out_valid_o/ out_stall_i| left_out_o, right_out_o
//   config    | in        | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One sample pair per clock cycle while the output is not stalled; a pair is captured
// in stage 1 on its transfer and moves on through stage 2 into the output register. Each
// delay line is one memory with one read and one write port: the read is issued on
// input transfer, the write-back happens when the pair leaves the feedback stage, and a
// bypass closes the shortest delay. Reset has no clearing pass: entries not yet written
// since reset read as zero through the write index and a wrap flag. Output stalls fill
// the free pipeline slots first; input stall rises only when every stage holds a pair.

module stereo_feedback_delay_unit
  import sfd_pkg::*;
#(
  parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input sample pairs
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  // mixed output pairs
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int CW   = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam int FP_W = SB + GAIN_W + 1;
  localparam int MP_W = SB + MIX_W + 1;
  localparam int MX_W = SB + MIX_W + 2;

  localparam logic signed [MX_W-1:0] RND   = MX_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [MX_W-1:0] S_MAX = {{(MX_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [MX_W-1:0] S_MIN = {{(MX_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic [CW-1:0]          D_MAX = CW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0]          W_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [AW:0]            DEPTH_X = (AW+1)'(LINE_DEPTH);

  function automatic logic signed [SB-1:0] sat_f(input logic signed [MX_W-1:0] x);
    logic signed [SB-1:0] r;
    if (x > S_MAX) begin
      r = S_MAX[SB-1:0];
    end else if (x < S_MIN) begin
      r = S_MIN[SB-1:0];
    end else begin
      r = x[SB-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0] delay_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [MIX_W-1:0]   wet_q;
  logic               ping_q;

  assign cfg_ready_o = 1'b1;

  // Take register writes, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_W'(1);
      gain_q  <= '0;
      wet_q   <= '0;
      ping_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DELAY_LENGTH:  delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_FEEDBACK_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_WET_MIX:       wet_q   <= cfg_data_i[MIX_W-1:0];
        CFG_PING_PONG:     ping_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp gains and delay into their legal ranges
  logic [GAIN_W-1:0] gain_c;
  logic [MIX_W-1:0]  wet_c;
  logic [MIX_W-1:0]  dry_c;
  logic [CW-1:0]     delay_x;
  logic [CW-1:0]     delay_cl;
  logic [AW-1:0]     delay_a;

  always_comb begin
    gain_c  = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
    wet_c   = (wet_q > MIX_ONE) ? MIX_ONE : wet_q;
    dry_c   = MIX_ONE - wet_c;
    delay_x = CW'(delay_q);
    if (delay_x == '0) begin
      delay_cl = CW'(1);
    end else if (delay_x > D_MAX) begin
      delay_cl = D_MAX;
    end else begin
      delay_cl = delay_x;
    end
    delay_a = delay_cl[AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv_out, adv2, adv1, accept, mem_we;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv2       = !s2_v_q || adv_out;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;
  assign mem_we     = s1_v_q && adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1)    s1_v_q  <= accept;
      if (adv2)    s2_v_q  <= s1_v_q;
      if (adv_out) out_v_q <= s2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Write index and read address
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wi_q, wi_d;
  logic          wrapped_q, wrapped_d;
  logic [AW:0]   rd_wrap;
  logic [AW-1:0] rd_addr;
  logic          rd_written;

  always_comb begin
    rd_wrap    = {1'b0, wi_q} + DEPTH_X - {1'b0, delay_a};
    rd_addr    = (wi_q >= delay_a) ? (wi_q - delay_a) : rd_wrap[AW-1:0];
    rd_written = wrapped_q || (rd_addr < wi_q);
    wi_d       = (wi_q == W_LAST) ? '0 : wi_q + AW'(1);
    wrapped_d  = wrapped_q || (wi_q == W_LAST);
  end

  // Advance the write position once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (accept) begin
      wi_q      <= wi_d;
      wrapped_q <= wrapped_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: delayed samples, feedback and write-back
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] s1_l_in_q, s1_r_in_q;
  logic [AW-1:0]        s1_wi_q;
  logic                 s1_byp_q, s1_zero_q;
  logic signed [SB-1:0] s1_bl_q, s1_br_q;
  logic signed [SB-1:0] l_rd_q, r_rd_q;

  logic signed [SB-1:0]   dl, dr;
  logic signed [FP_W-1:0] fbp_l, fbp_r;
  logic signed [MX_W-1:0] fb_l, fb_r;
  logic signed [MX_W-1:0] wsum_l, wsum_r;
  logic signed [SB-1:0]   wl, wr;
  logic signed [MP_W-1:0] mxa_l, mxb_l, mxa_r, mxb_r;

  always_comb begin
    if (s1_byp_q) begin
      dl = s1_bl_q;
      dr = s1_br_q;
    end else if (s1_zero_q) begin
      dl = '0;
      dr = '0;
    end else begin
      dl = l_rd_q;
      dr = r_rd_q;
    end
    fbp_l = dl * $signed({1'b0, gain_c});
    fbp_r = dr * $signed({1'b0, gain_c});
    fb_l  = (MX_W'(fbp_l) + RND) >>> FRAC_BITS;
    fb_r  = (MX_W'(fbp_r) + RND) >>> FRAC_BITS;
    // cross-feed swaps which input and which echo each line takes
    if (ping_q) begin
      wsum_l = MX_W'(s1_r_in_q) + fb_r;
      wsum_r = MX_W'(s1_l_in_q) + fb_l;
    end else begin
      wsum_l = MX_W'(s1_l_in_q) + fb_l;
      wsum_r = MX_W'(s1_r_in_q) + fb_r;
    end
    wl    = sat_f(wsum_l);
    wr    = sat_f(wsum_r);
    mxa_l = s1_l_in_q * $signed({1'b0, dry_c});
    mxb_l = dl * $signed({1'b0, wet_c});
    mxa_r = s1_r_in_q * $signed({1'b0, dry_c});
    mxb_r = dr * $signed({1'b0, wet_c});
  end

  // Capture input pair, read tags and bypass from the pair ahead
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_l_in_q <= left_in_i;
      s1_r_in_q <= right_in_i;
      s1_wi_q   <= wi_q;
      s1_byp_q  <= s1_v_q && (s1_wi_q == rd_addr);
      s1_zero_q <= !rd_written;
      s1_bl_q   <= wl;
      s1_br_q   <= wr;
    end
  end

  // Delay line memories
  logic [SB-1:0] l_mem [LINE_DEPTH];
  logic [SB-1:0] r_mem [LINE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) l_mem[s1_wi_q] <= wl;
    if (accept) l_rd_q <= l_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) r_mem[s1_wi_q] <= wr;
    if (accept) r_rd_q <= r_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dry/wet mix
  // ---------------------------------------------------------------------------
  logic signed [MP_W-1:0] s2_al_q, s2_bl_q, s2_ar_q, s2_br_q;
  logic signed [MX_W-1:0] mix_l, mix_r;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      s2_al_q <= mxa_l;
      s2_bl_q <= mxb_l;
      s2_ar_q <= mxa_r;
      s2_br_q <= mxb_r;
    end
  end

  always_comb begin
    mix_l = (MX_W'(s2_al_q) + MX_W'(s2_bl_q) + RND) >>> FRAC_BITS;
    mix_r = (MX_W'(s2_ar_q) + MX_W'(s2_br_q) + RND) >>> FRAC_BITS;
  end

  // Output register: hold while stalled
  logic signed [SB-1:0] left_out_q, right_out_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q && adv_out) begin
      left_out_q  <= sat_f(mix_l);
      right_out_q <= sat_f(mix_r);
    end
  end

  assign out_valid_o = out_v_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

// File: design/sfd_checker.sv
// Port-level checks for the stereo feedback delay, bound to the top level.
// Depends on sfd_pkg and stereo_feedback_delay_unit.

module sfd_checker
  import sfd_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(left_out_o) && $stable(right_out_o)))
    else $error("output changed while stalled");

  // Input back-pressure only when the full pipeline is blocked at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // A transferred pair reaches the output register through stage 1 and stage 2
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##3 out_valid_o)
    else $error("result missing three cycles after input transfer");

  // Register writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind stereo_feedback_delay_unit sfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfd_checker (.*);
